[rtl/lca_pkg.sv]
package lca_pkg;
  localparam int unsigned NodesDef = 65536;
  localparam int unsigned LevelsDef = 16;
  localparam int unsigned NodeW = 16;
  localparam int unsigned DepthW = 16;
  localparam logic OpAttach = 1'b0;
  localparam logic OpQuery = 1'b1;
endpackage

[rtl/lca_mem.sv]
module lca_mem #(
  parameter int unsigned NODES = lca_pkg::NodesDef,
  parameter int unsigned LEVELS = lca_pkg::LevelsDef,
  parameter int unsigned AW = 20
) (
  input  logic                       clk,
  input  logic                       jt_we,
  input  logic [AW-1:0]              jt_waddr,
  input  logic [lca_pkg::NodeW-1:0]  jt_wdata,
  input  logic [AW-1:0]              jt_raddr,
  output logic [lca_pkg::NodeW-1:0]  jt_rdata,
  input  logic                       nd_we,
  input  logic [$clog2(NODES)-1:0]   nd_waddr,
  input  logic [lca_pkg::DepthW-1:0] nd_wdata,
  input  logic [$clog2(NODES)-1:0]   nd_raddr,
  output logic [lca_pkg::DepthW-1:0] nd_rdata
);
  import lca_pkg::*;
  localparam int unsigned JtDepth = NODES * LEVELS;
  logic [NodeW-1:0]  jt_mem [JtDepth];
  logic [DepthW-1:0] nd_mem [NODES];

  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt_mem[jt_waddr] <= jt_wdata;
    end
    jt_rdata <= jt_mem[jt_raddr];
  end

  always_ff @(posedge clk) begin
    if (nd_we) begin
      nd_mem[nd_waddr] <= nd_wdata;
    end
    nd_rdata <= nd_mem[nd_raddr];
  end
endmodule

[rtl/lowest_common_ancestor_lifting.sv]
// lowest common ancestor by binary lifting over a forest of NODES nodes
// input channel in_*: tdata = {node_b, node_a}, tuser = opcode
//   opcode 0 attaches node_a under parent node_b (0 makes a root)
//   opcode 1 queries the common ancestor of node_a and node_b
// output channel out_*: tdata = {result_depth, result_node}, tuser = error
// one result per transfer; one item is processed at a time
// attach: the new node's ancestor row is filled level by level; each row
//   entry is a read of an ancestor's jump entry followed by a write, in
//   turn through the states S_AT_RD, S_AT_RW and S_AT_WR
// query: two lifting passes, the first reading jump entries and node depths
//   one after the other, the second reading jump entries only
// rejected items, also an attach under a parent at the deepest depth, set out_tuser
// node valid marks sit in a memory that is swept after reset, entry by
//   entry, during which no input is taken
// in_tready is low while an item is in work and while a finished result
//   waits for out_tready; the result holds until taken
module lowest_common_ancestor_lifting #(
  parameter int unsigned NODES = lca_pkg::NodesDef,
  parameter int unsigned LEVELS = lca_pkg::LevelsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // node_a [15:0], node_b [31:16]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_node [15:0], result_depth [31:16]
  output logic        out_tuser   // error
);
  import lca_pkg::*;
  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned AW = $clog2(NODES * LEVELS);
  localparam logic [LW-1:0] LTop = LW'(LEVELS - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHK_A, S_CHK_B, S_CHK_W,
    S_AT_RD, S_AT_RW, S_AT_WR, S_AT_FIN,
    S_Q_DEP, S_Q_DW, S_L1_RD, S_L1_RW, S_L1_DW, S_L1_DC,
    S_EQ, S_L2_RU, S_L2_RV, S_L2_WV, S_L2_CMP, S_R_RD, S_R_RW, S_R_DW, S_R_FIN,
    S_OUT
  } state_t;

  state_t state_r;
  logic [NW-1:0] clr_r;
  logic          op_r;
  logic [NodeW-1:0] a_r, b_r, u_r, v_r, t_r, tu_r, res_r;
  logic [DepthW-1:0] da_r, du_r, dres_r;
  logic [LW-1:0] lv_r;
  logic err_r, ova_r, ovb_r;

  logic vmem [NODES];
  logic v_we, v_wd, v_rd;
  logic [NW-1:0] v_wa, v_ra;

  logic jt_we, nd_we;
  logic [AW-1:0] jt_wa, jt_ra;
  logic [NodeW-1:0] jt_wd, jt_rd;
  logic [NW-1:0] nd_wa, nd_ra;
  logic [DepthW-1:0] nd_wd, nd_rd;

  lca_mem #(.NODES(NODES), .LEVELS(LEVELS), .AW(AW)) u_mem (
    .clk(clk), .jt_we(jt_we), .jt_waddr(jt_wa), .jt_wdata(jt_wd), .jt_raddr(jt_ra),
    .jt_rdata(jt_rd), .nd_we(nd_we), .nd_waddr(nd_wa), .nd_wdata(nd_wd),
    .nd_raddr(nd_ra), .nd_rdata(nd_rd)
  );

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
    v_rd <= vmem[v_ra];
  end

  function automatic logic [AW-1:0] jaddr(input logic [NodeW-1:0] n,
                                          input logic [LW-1:0] l);
    logic [AW+NodeW-1:0] p;
    p = (AW+NodeW)'(n) * (AW+NodeW)'(LEVELS) + (AW+NodeW)'(l);
    return p[AW-1:0];
  endfunction

  function automatic logic inrange(input logic [NodeW-1:0] n);
    return {16'd0, n} < 32'(NODES);
  endfunction

  logic [NodeW-1:0] in_a, in_b;
  assign in_a = in_tdata[15:0];
  assign in_b = in_tdata[31:16];
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {dres_r, res_r};
  assign out_tuser = err_r;

  always_comb begin
    v_we = 1'b0; v_wd = 1'b0; v_wa = clr_r; v_ra = a_r[NW-1:0];
    jt_we = 1'b0; jt_wa = jaddr(a_r, lv_r); jt_wd = b_r; jt_ra = jaddr(t_r, lv_r);
    nd_we = 1'b0; nd_wa = a_r[NW-1:0]; nd_wd = da_r; nd_ra = b_r[NW-1:0];
    unique case (state_r)
      S_CLR: v_we = 1'b1;
      S_IDLE: v_ra = in_a[NW-1:0];
      S_CHK_A, S_CHK_B: v_ra = b_r[NW-1:0];
      S_AT_RD: jt_ra = jaddr(t_r, lv_r - LW'(1));
      S_AT_WR: begin
        jt_we = 1'b1; jt_wd = t_r;
      end
      S_AT_FIN: begin
        nd_we = 1'b1; v_we = 1'b1; v_wd = 1'b1; v_wa = a_r[NW-1:0];
        jt_we = 1'b1; jt_wa = jaddr(a_r, '0); jt_wd = b_r;
      end
      S_Q_DEP, S_Q_DW: nd_ra = a_r[NW-1:0];
      S_L1_RD: jt_ra = jaddr(v_r, lv_r);
      S_L1_RW: nd_ra = jt_rd[NW-1:0];
      S_L1_DW: nd_ra = t_r[NW-1:0];
      S_L2_RU: jt_ra = jaddr(u_r, lv_r);
      S_L2_RV: jt_ra = jaddr(v_r, lv_r);
      S_R_RD: jt_ra = jaddr(u_r, '0);
      S_R_RW: nd_ra = jt_rd[NW-1:0];
      S_R_DW: nd_ra = res_r[NW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + NW'(1);
          if (clr_r == NW'(NODES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tuser; a_r <= in_a; b_r <= in_b;
          ova_r <= inrange(in_a) && (in_a != '0);
          ovb_r <= inrange(in_b);
          state_r <= S_CHK_A;
        end
        S_CHK_A: begin
          ova_r <= ova_r && v_rd;
          state_r <= S_CHK_B;
        end
        S_CHK_B: state_r <= S_CHK_W;
        S_CHK_W: begin
          // v_rd now holds valid mark of b
          err_r <= 1'b0; res_r <= '0; dres_r <= '0;
          if (op_r == OpAttach) begin
            if (!(inrange(a_r) && a_r != '0) || ova_r ||
                (b_r != '0 && !(ovb_r && v_rd))) begin
              err_r <= 1'b1; state_r <= S_OUT;
            end else if (b_r == '0) begin
              da_r <= '0; t_r <= '0; lv_r <= LW'(1);
              state_r <= (LEVELS > 1) ? S_AT_RD : S_AT_FIN;
            end else begin
              t_r <= b_r; lv_r <= '0; state_r <= S_Q_DW;
            end
          end else begin
            if (!ova_r || b_r == '0 || !(ovb_r && v_rd)) begin
              err_r <= 1'b1; state_r <= S_OUT;
            end else begin
              state_r <= S_Q_DEP;
            end
          end
        end
        S_Q_DEP: begin
          // nd_rd is depth of b
          da_r <= nd_rd;
          state_r <= S_Q_DW;
        end
        S_Q_DW: begin
          if (op_r == OpAttach) begin
            // nd_rd is depth of parent
            if (nd_rd == '1) begin
              err_r <= 1'b1; state_r <= S_OUT;
            end else begin
              da_r <= nd_rd + DepthW'(1);
              t_r <= b_r; lv_r <= LW'(1);
              state_r <= (LEVELS > 1) ? S_AT_RD : S_AT_FIN;
            end
          end else begin
            state_r <= S_L1_DC;
            lv_r <= '0;
          end
        end
        S_L1_DC: begin
          // nd_rd = depth(a), da_r = depth(b)
          if (nd_rd > da_r) begin
            u_r <= b_r; du_r <= da_r; v_r <= a_r;
          end else begin
            u_r <= a_r; du_r <= nd_rd; v_r <= b_r;
          end
          lv_r <= LTop;
          state_r <= S_L1_RD;
        end
        S_AT_RD: state_r <= S_AT_RW;
        S_AT_RW: begin
          // t_r = ancestor at lv-1, jt_rd = its ancestor at lv-1
          t_r <= (t_r == '0) ? '0 : jt_rd;
          state_r <= S_AT_WR;
        end
        S_AT_WR: begin
          if (lv_r == LTop) begin
            state_r <= S_AT_FIN;
          end else begin
            lv_r <= lv_r + LW'(1);
            state_r <= S_AT_RD;
          end
        end
        S_AT_FIN: begin
          res_r <= a_r; dres_r <= da_r; state_r <= S_OUT;
        end
        S_L1_RD: state_r <= S_L1_RW;
        S_L1_RW: begin
          t_r <= (v_r == '0) ? '0 : jt_rd;
          state_r <= S_L1_DW;
        end
        S_L1_DW: state_r <= S_EQ;
        S_EQ: begin
          if (t_r != '0 && nd_rd >= du_r) v_r <= t_r;
          if (lv_r == '0) begin
            state_r <= S_L2_CMP;
            lv_r <= LTop;
          end else begin
            lv_r <= lv_r - LW'(1);
            state_r <= S_L1_RD;
          end
        end
        S_L2_CMP: begin
          if (u_r == v_r) begin
            res_r <= u_r; state_r <= S_R_DW; t_r <= u_r;
          end else begin
            state_r <= S_L2_RU;
          end
        end
        S_L2_RU: state_r <= S_L2_RV;
        S_L2_RV: begin
          tu_r <= (u_r == '0) ? '0 : jt_rd;
          state_r <= S_L2_WV;
        end
        S_L2_WV: begin
          if (((v_r == '0) ? '0 : jt_rd) != tu_r) begin
            u_r <= tu_r; v_r <= (v_r == '0) ? '0 : jt_rd;
          end
          if (lv_r == '0) begin
            state_r <= S_R_RD;
          end else begin
            lv_r <= lv_r - LW'(1);
            state_r <= S_L2_RU;
          end
        end
        S_R_RD: state_r <= S_R_RW;
        S_R_RW: begin
          res_r <= (u_r == '0) ? '0 : jt_rd;
          t_r <= (u_r == '0) ? '0 : jt_rd;
          state_r <= S_R_FIN;
        end
        S_R_DW: begin
          t_r <= res_r; state_r <= S_R_FIN;
        end
        S_R_FIN: begin
          // nd_rd is depth of the result node
          dres_r <= (res_r == '0) ? '0 : nd_rd;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[sim/lowest_common_ancestor_lifting_tb.sv]
module lowest_common_ancestor_lifting_tb;
  import lca_pkg::*;

  localparam int unsigned LEVELS = LevelsDef;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic              op;
    logic [NodeW-1:0]  node_a;
    logic [NodeW-1:0]  node_b;
  } lca_item_t;

  typedef struct packed {
    logic [NodeW-1:0]  node;
    logic [DepthW-1:0] depth;
    logic              err;
  } lca_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // node_a [15:0], node_b [31:16]
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // result_node [15:0], result_depth [31:16]
  logic        out_tuser;  // error

  lowest_common_ancestor_lifting u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // shadow forest
  bit [NodeW-1:0]  anc_tab [0:NodesDef-1][0:LEVELS-1];
  bit [DepthW-1:0] dep_tab [0:NodesDef-1];
  bit              attached [0:NodesDef-1];

  lca_item_t   pending_items[$];
  lca_result_t expected_results[$];
  int          accepted_cnt;
  int          mismatch_cnt;
  int          cycle_cnt;
  bit          in_taken;
  int          hold_left;
  bit          hold_done;

  function automatic bit [NodeW-1:0] hop(bit [NodeW-1:0] u, int lv);
    if (u == 0) return '0;
    return anc_tab[u][lv];
  endfunction

  function automatic bit usable(bit [NodeW-1:0] u);
    return u != 0 && attached[u];
  endfunction

  function automatic lca_result_t lca_step(lca_item_t it);
    lca_result_t res;
    bit [NodeW-1:0] u, v, t, tu, tv, r;
    bit [DepthW-1:0] d;
    res = '{node: '0, depth: '0, err: 1'b1};
    if (it.op == OpAttach) begin
      if (it.node_a == 0 || attached[it.node_a]) return res;
      d = '0;
      if (it.node_b != 0) begin
        if (!usable(it.node_b) || dep_tab[it.node_b] == '1) return res;
        d = dep_tab[it.node_b] + 1'b1;
      end
      anc_tab[it.node_a][0] = it.node_b;
      for (int lv = 1; lv < LEVELS; lv++)
        anc_tab[it.node_a][lv] = hop(anc_tab[it.node_a][lv-1], lv - 1);
      dep_tab[it.node_a] = d;
      attached[it.node_a] = 1'b1;
      return '{node: it.node_a, depth: d, err: 1'b0};
    end
    if (!usable(it.node_a) || !usable(it.node_b)) return res;
    u = it.node_a;
    v = it.node_b;
    if (dep_tab[u] > dep_tab[v]) begin
      t = u; u = v; v = t;
    end
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      t = hop(v, lv);
      if (t != 0 && dep_tab[t] >= dep_tab[u]) v = t;
    end
    if (u == v) begin
      r = u;
    end else begin
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
        tu = hop(u, lv);
        tv = hop(v, lv);
        if (tu != tv) begin
          u = tu; v = tv;
        end
      end
      r = hop(u, 0);
    end
    return '{node: r, depth: (r != 0) ? dep_tab[r] : '0, err: 1'b0};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idling is suppressed over a window of transfers
  function automatic bit idle_now();
    if (accepted_cnt >= 100 && accepted_cnt < 250) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_items.size() > 0 && !idle_now()) begin
        lca_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {it.node_b, it.node_a};
        in_tuser  <= it.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
    end
  end

  // monitor
  always @(posedge clk) begin
    lca_result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      cycle_cnt++;
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        accepted_cnt++;
        expected_results = {expected_results,
                            lca_step('{op: in_tuser, node_a: in_tdata[15:0],
                                       node_b: in_tdata[31:16]})};
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual node %h depth %h error %b",
                   $time, out_tdata[15:0], out_tdata[31:16], out_tuser);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[15:0] !== want.node || out_tdata[31:16] !== want.depth ||
              out_tuser !== want.err) begin
            $display("%0t: expected node %h depth %h error %b, actual node %h depth %h error %b",
                     $time, want.node, want.depth, want.err,
                     out_tdata[15:0], out_tdata[31:16], out_tuser);
            mismatch_cnt++;
          end
        end
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic add_item(logic op, logic [15:0] a, logic [15:0] b);
    lca_item_t it;
    it = '{op: op, node_a: a, node_b: b};
    pending_items = {pending_items, it};
  endtask

  initial begin
    int planned[$];
    bit [15:0] n, p;
    int sel;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OpAttach;
    out_tready = 1'b0;
    in_taken = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    accepted_cnt = 0;
    mismatch_cnt = 0;
    cycle_cnt = 0;

    // directed part
    add_item(OpAttach, 16'hFFFF, 16'h0000);   // root with all bits set
    add_item(OpAttach, 16'h0001, 16'h0000);   // second tree
    add_item(OpAttach, 16'h0002, 16'hFFFF);
    add_item(OpAttach, 16'h0003, 16'h0002);
    add_item(OpAttach, 16'h0004, 16'h0002);
    add_item(OpAttach, 16'h0005, 16'h0003);
    add_item(OpAttach, 16'h0000, 16'h0001);   // sentinel node
    add_item(OpAttach, 16'h0003, 16'h0001);   // already attached
    add_item(OpAttach, 16'h0006, 16'h1234);   // parent not attached
    add_item(OpQuery,  16'h0005, 16'h0004);
    add_item(OpQuery,  16'h0004, 16'h0005);
    add_item(OpQuery,  16'h0005, 16'hFFFF);   // ancestor and descendant
    add_item(OpQuery,  16'h0003, 16'h0003);   // same node
    add_item(OpQuery,  16'h0005, 16'h0001);   // different trees
    add_item(OpQuery,  16'h0000, 16'h0005);   // sentinel in query
    add_item(OpQuery,  16'h0005, 16'h0000);
    add_item(OpQuery,  16'h7777, 16'h0005);   // unattached node
    add_item(OpQuery,  16'h8000, 16'hFFFF);
    planned = '{16'hFFFF, 1, 2, 3, 4, 5};

    // random part: mostly growth and queries on the live forest
    for (int i = 0; i < 650; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        do n = 16'($urandom); while (n == 0 || n inside {planned});
        if ($urandom_range(9) == 0) p = 0;
        else if ($urandom_range(1)) p = 16'(planned[planned.size() - 1]);
        else p = 16'(planned[$urandom_range(planned.size() - 1)]);
        add_item(OpAttach, n, p);
        planned = {planned, int'(n)};
      end else if (sel < 85) begin
        add_item(OpQuery, 16'(planned[$urandom_range(planned.size() - 1)]),
                 16'(planned[$urandom_range(planned.size() - 1)]));
      end else begin
        add_item(1'($urandom_range(1)), 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_items.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[files.f]
rtl/lca_pkg.sv
rtl/lca_mem.sv
rtl/lowest_common_ancestor_lifting.sv
sim/lowest_common_ancestor_lifting_tb.sv
